>>> rtl/adl64_pkg.sv
// Package for the Adler checksum over 64-bit words.
// Holds the modulus, sum widths and fold constants; no dependencies.
package adl64_pkg;

  localparam int unsigned SUM_W   = 16;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CSUM_W  = 2 * SUM_W;

  localparam logic [SUM_W-1:0] ADLER_MOD = 16'd65521;

  // Residues of 2^16, 2^32 and 2^48 modulo 65521
  localparam logic [3:0]  FOLD_16 = 4'd15;
  localparam logic [7:0]  FOLD_32 = 8'd225;
  localparam logic [11:0] FOLD_48 = 12'd3375;

  typedef logic [SUM_W-1:0] sum_t;

endpackage

>>> rtl/adl64_fold.sv
// Reduces one 64-bit word modulo 65521 by folding 16-bit digits.
// Depends on adl64_pkg.
module adl64_fold (
  input  logic [adl64_pkg::WORD_W-1:0] word_i,
  output adl64_pkg::sum_t              residue_o
);
  import adl64_pkg::*;

  logic [27:0] fold1;
  logic [16:0] fold2;
  logic [16:0] fold3;

  always_comb begin
    fold1 = 28'(word_i[15:0])
          + 28'(word_i[31:16]) * 28'(FOLD_16)
          + 28'(word_i[47:32]) * 28'(FOLD_32)
          + 28'(word_i[63:48]) * 28'(FOLD_48);
    fold2 = 17'(fold1[27:16]) * 17'(FOLD_16) + 17'(fold1[15:0]);
    fold3 = 17'(fold2[16] ? FOLD_16 : 4'd0) + 17'(fold2[15:0]);
    residue_o = (fold3 >= 17'(ADLER_MOD)) ? 16'(fold3 - 17'(ADLER_MOD)) : fold3[15:0];
  end

endmodule

>>> rtl/adler_checksum_64bit_words_core.sv
// Adler-style checksum over messages of 64-bit words, top level.
// Depends on adl64_pkg and adl64_fold.
//
// Use:
//   s_axis carries one message word per item in tdata, tlast marks the
//   final word of a message. m_axis carries one checksum item per message,
//   {sum B, sum A}, each modulo 65521.
//   One word is taken every cycle unless a last word waits in the residue
//   stage. Each word is reduced modulo 65521 into a registered residue,
//   then added into the A and B accumulators as that stage advances; for
//   a last word the checksum lands in the output register on that edge.
//   The residue register and then the output register lie between the last
//   word accepted and m_axis_tvalid_o.
//   Reset empties both stages and sets A to 1 and B to 0.
//   While a checksum waits in the output register and m_axis_tready_i is
//   low, words that are not last keep flowing into the sums; a last word
//   holds in the residue stage and input backs up behind it.
module adler_checksum_64bit_words_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [adl64_pkg::WORD_W-1:0]  s_axis_tdata_i,  // [63:0] data_word
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [adl64_pkg::CSUM_W-1:0]  m_axis_tdata_o   // [15:0] A, [31:16] B
);
  import adl64_pkg::*;

  sum_t                residue;
  logic                res_vld_q;
  logic                res_last_q;
  sum_t                res_q;
  logic                res_go;
  logic                out_free;
  sum_t                sum_low_q, sum_low_d;
  sum_t                sum_high_q, sum_high_d;
  sum_t                a_new, b_new;
  logic [SUM_W:0]      a_sum, b_sum;
  logic                out_vld_q;
  logic [CSUM_W-1:0]   out_q;

  adl64_fold u_fold (
    .word_i    (s_axis_tdata_i),
    .residue_o (residue)
  );

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign res_go          = res_vld_q && (!res_last_q || out_free);
  assign s_axis_tready_o = !res_vld_q || res_go;

  always_comb begin
    a_sum = {1'b0, sum_low_q} + {1'b0, res_q};
    a_new = (a_sum >= {1'b0, ADLER_MOD}) ? SUM_W'(a_sum - {1'b0, ADLER_MOD}) : a_sum[SUM_W-1:0];
    b_sum = {1'b0, sum_high_q} + {1'b0, a_new};
    b_new = (b_sum >= {1'b0, ADLER_MOD}) ? SUM_W'(b_sum - {1'b0, ADLER_MOD}) : b_sum[SUM_W-1:0];
    sum_low_d  = sum_low_q;
    sum_high_d = sum_high_q;
    if (res_go) begin
      if (res_last_q) begin
        sum_low_d  = SUM_W'(1);
        sum_high_d = '0;
      end else begin
        sum_low_d  = a_new;
        sum_high_d = b_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q  <= 1'b0;
      sum_low_q  <= SUM_W'(1);
      sum_high_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        res_vld_q <= s_axis_tvalid_i;
      end
      sum_low_q  <= sum_low_d;
      sum_high_q <= sum_high_d;
      if (res_go && res_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      res_q      <= residue;
      res_last_q <= s_axis_tlast_i;
    end
    if (res_go && res_last_q) begin
      out_q <= {b_new, a_new};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_low_q < ADLER_MOD) && (sum_high_q < ADLER_MOD))
    else $error("running sums out of range");

  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q[SUM_W-1:0] < ADLER_MOD) && (out_q[CSUM_W-1:SUM_W] < ADLER_MOD))
    else $error("checksum halves out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_go && res_last_q) |=> (sum_low_q == SUM_W'(1)) && (sum_high_q == '0) && out_vld_q)
    else $error("sums not restarted after last word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> out_vld_q && $stable(out_q))
    else $error("pending checksum overwritten");
`endif

endmodule
